// ----- rtl/cfl_pkg.sv -----
package cfl_pkg;

    localparam int DEFAULT_POOL_DEPTH = 64;
    localparam int SLOT_FIELD_LIMIT   = 64;
    localparam int SIZE_W             = 7;
    localparam int SLOT_W             = 6;

    localparam logic OP_ACQUIRE = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_EMPTY      = 2'd1;
    localparam logic [1:0] ST_ALREADY    = 2'd2;
    localparam logic [1:0] ST_OUT_RANGE  = 2'd3;

    typedef struct packed {
        logic              opcode;
        logic [SLOT_W-1:0] release_index;
        logic              conn_alive;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [SLOT_W-1:0] slot_index;
    } out_beat_t;

endpackage

// ----- rtl/cfl_list.sv -----
module cfl_list #(
    parameter int SLOTS = cfl_pkg::SLOT_FIELD_LIMIT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [cfl_pkg::SIZE_W-1:0]     cfg_wr_data,
    input  logic                           step,
    input  cfl_pkg::in_beat_t              req,
    output cfl_pkg::out_beat_t             rsp
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [cfl_pkg::SIZE_W-1:0] SLOTS_N = cfl_pkg::SIZE_W'(SLOTS);

    logic [IW-1:0]                link_mem [SLOTS];
    logic [IW-1:0]                link_rd_reg;
    logic [SLOTS-1:0]             written_reg;
    logic                         link_hit_reg;
    logic [IW-1:0]                link_alt_reg;
    logic [SLOTS-1:0]             used_reg;
    logic [IW-1:0]                head_reg;
    logic [IW-1:0]                tail_reg;
    logic                         empty_reg;
    logic [cfl_pkg::SIZE_W-1:0]   size_reg;

    logic [cfl_pkg::SIZE_W-1:0]   size_next;
    logic [IW-1:0]                head_next;
    logic [IW-1:0]                tail_next;
    logic                         empty_next;
    logic                         link_hit_next;
    logic [IW-1:0]                link_alt_next;
    logic                         wr_en;
    logic [IW-1:0]                wr_addr;
    logic [IW-1:0]                wr_data;
    logic                         fwd;
    logic [IW-1:0]                head_link;
    logic [IW-1:0]                rel;
    logic                         out_range;
    logic                         rel_ok;

    // clamp the written size to 1..SLOTS
    always_comb
    begin
        if (cfg_wr_data == '0)
            size_next = cfl_pkg::SIZE_W'(1);
        else if (cfg_wr_data > SLOTS_N)
            size_next = SLOTS_N;
        else
            size_next = cfg_wr_data;
    end

    // link of the head slot, prefetched at the previous edge
    assign head_link = link_hit_reg ? link_rd_reg : link_alt_reg;
    assign out_range = {1'b0, req.release_index} >= size_reg;
    assign rel       = req.release_index[IW-1:0];
    assign rel_ok    = !out_range && used_reg[rel];

    always_comb
    begin
        rsp = '0;
        if (req.opcode == cfl_pkg::OP_ACQUIRE)
        begin
            if (empty_reg)
                rsp.status = cfl_pkg::ST_EMPTY;
            else
                rsp.slot_index = cfl_pkg::SLOT_W'(head_reg);
        end
        else
        begin
            if (out_range)
                rsp.status = cfl_pkg::ST_OUT_RANGE;
            else if (!used_reg[rel])
                rsp.status = cfl_pkg::ST_ALREADY;
        end
    end

    // the tail's own link is kept only in head_reg
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        empty_next = empty_reg;
        wr_en      = 1'b0;
        wr_addr    = tail_reg;
        wr_data    = rel;
        if (cfg_wr_en)
        begin
            head_next  = '0;
            tail_next  = IW'(size_next - cfl_pkg::SIZE_W'(1));
            empty_next = 1'b0;
        end
        else if (step)
        begin
            if (req.opcode == cfl_pkg::OP_ACQUIRE)
            begin
                if (!empty_reg)
                begin
                    if (head_reg == tail_reg)
                        empty_next = 1'b1;
                    else
                        head_next = head_link;
                end
            end
            else if (rel_ok)
            begin
                if (empty_reg)
                begin
                    head_next  = rel;
                    tail_next  = rel;
                    empty_next = 1'b0;
                end
                else if (req.conn_alive)
                begin
                    // healthy slot becomes the head
                    wr_en     = 1'b1;
                    wr_addr   = rel;
                    wr_data   = head_reg;
                    head_next = rel;
                end
                else
                begin
                    // dead slot becomes the tail
                    wr_en     = 1'b1;
                    wr_addr   = tail_reg;
                    wr_data   = rel;
                    tail_next = rel;
                end
            end
        end
    end

    // unwritten links read as the rebuilt chain i to i+1
    assign fwd           = wr_en && (wr_addr == head_next);
    assign link_hit_next = !cfg_wr_en && !fwd && written_reg[head_next];
    assign link_alt_next = fwd ? wr_data : head_next + IW'(1);

    always_ff @(posedge clk)
    begin
        if (wr_en)
            link_mem[wr_addr] <= wr_data;
        link_rd_reg <= link_mem[head_next];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg     <= '0;
            written_reg  <= '0;
            head_reg     <= '0;
            tail_reg     <= IW'(SLOTS - 1);
            empty_reg    <= 1'b0;
            size_reg     <= SLOTS_N;
            link_hit_reg <= 1'b0;
            link_alt_reg <= IW'(1);
        end
        else
        begin
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            empty_reg    <= empty_next;
            link_hit_reg <= link_hit_next;
            link_alt_reg <= link_alt_next;
            if (cfg_wr_en)
            begin
                size_reg    <= size_next;
                written_reg <= '0;
                for (int k = 0; k < SLOTS; k++)
                    used_reg[k] <= (cfl_pkg::SIZE_W'(k + 1) > size_next);
            end
            else
            begin
                if (wr_en)
                    written_reg[wr_addr] <= 1'b1;
                if (step && req.opcode == cfl_pkg::OP_ACQUIRE && !empty_reg)
                    used_reg[head_reg] <= 1'b1;
                if (step && req.opcode == cfl_pkg::OP_RELEASE && rel_ok)
                    used_reg[rel] <= 1'b0;
            end
        end
    end

endmodule

// ----- rtl/circular_free_list_pool.sv -----
// the head's link is prefetched from the link memory; in_data_reg registers a beat,
// then out_data_reg its result; one beat per cycle unless out_stall holds
// reset: asynchronous, active low; all slots free, chain i to i+1, size SLOTS
// a pool_size write rebuilds the list in the same cycle
module circular_free_list_pool #(
    parameter int POOL_DEPTH = cfl_pkg::DEFAULT_POOL_DEPTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  cfl_pkg::in_beat_t            in_data,
    output logic                         out_valid,
    input  logic                         out_stall,
    output cfl_pkg::out_beat_t           out_data,
    input  logic                         cfg_wr_en,
    input  logic [cfl_pkg::SIZE_W-1:0]   cfg_wr_data
);

    localparam int SLOTS = (POOL_DEPTH < cfl_pkg::SLOT_FIELD_LIMIT)
                           ? POOL_DEPTH : cfl_pkg::SLOT_FIELD_LIMIT;

    logic                in_valid_reg;
    cfl_pkg::in_beat_t   in_data_reg;
    logic                out_valid_reg;
    cfl_pkg::out_beat_t  out_data_reg;
    cfl_pkg::out_beat_t  rsp;
    logic                advance;
    logic                step;

    assign advance  = !out_valid_reg || !out_stall;
    assign step     = in_valid_reg && advance;
    assign in_stall = in_valid_reg && !advance;

    cfl_list #(
        .SLOTS (SLOTS)
    ) u_list (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .step        (step),
        .req         (in_data_reg),
        .rsp         (rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
                in_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
            in_data_reg <= in_data;
        if (step)
            out_data_reg <= rsp;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb;

    localparam int DEPTH = cfl_pkg::DEFAULT_POOL_DEPTH;
    localparam logic [6:0] LINK_TAKEN = 7'h7F;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASE_ITEMS = 200;
    localparam int PHASE_SIZES [10] = '{64, 1, 2, 127, 0, 3, 64, 40, 9, 65};
    localparam int ACQ_PCT [2] = '{92, 20};

    typedef struct {
        bit                 typed;
        cfl_pkg::out_beat_t result;
    } beat_note_t;

    typedef struct {
        bit                         is_cfg;
        logic [cfl_pkg::SIZE_W-1:0] size_val;
        cfl_pkg::in_beat_t          beat;
        bit                         typed;
        cfl_pkg::out_beat_t         result;
    } stim_row_t;

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_stall;
    cfl_pkg::in_beat_t           in_data;
    logic                        out_valid;
    logic                        out_stall;
    cfl_pkg::out_beat_t          out_data;
    logic                        cfg_wr_en;
    logic [cfl_pkg::SIZE_W-1:0]  cfg_wr_data;

    // free list mirror
    logic [6:0]                  slot_link [DEPTH];
    int                          tail_slot_m;
    bit                          pool_drained;
    logic [cfl_pkg::SIZE_W-1:0]  pool_size_m;

    cfl_pkg::out_beat_t          expected_grants [$];
    beat_note_t                  beat_notes [$];
    int                          beats_in;
    int                          beats_out;
    int                          err_count;
    int                          quiet_cycles;
    bit                          in_burst;
    bit                          out_burst;

    circular_free_list_pool dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int live_slots();
        int n;
        n = int'(pool_size_m);
        if (n < 1)
            n = 1;
        if (n > DEPTH)
            n = DEPTH;
        if (n > cfl_pkg::SLOT_FIELD_LIMIT)
            n = cfl_pkg::SLOT_FIELD_LIMIT;
        return n;
    endfunction

    function automatic void rebuild_pool();
        int n;
        n = live_slots();
        for (int k = 0; k < DEPTH; k++)
        begin
            if (k + 1 < n)
                slot_link[k] = 7'(k + 1);
            else if (k + 1 == n)
                slot_link[k] = 7'd0;
            else
                slot_link[k] = LINK_TAKEN;
        end
        tail_slot_m = n - 1;
        pool_drained = 1'b0;
    endfunction

    function automatic cfl_pkg::out_beat_t predict_grant(input cfl_pkg::in_beat_t b);
        cfl_pkg::out_beat_t r;
        int n;
        int t;
        int h;
        int idx;
        r = '0;
        r.status = cfl_pkg::ST_OK;
        n = live_slots();
        idx = int'(b.release_index);
        if (b.opcode == cfl_pkg::OP_ACQUIRE)
        begin
            if (pool_drained)
                r.status = cfl_pkg::ST_EMPTY;
            else
            begin
                t = tail_slot_m % n;
                h = int'(slot_link[t]) % n;
                if (h == t)
                    pool_drained = 1'b1;
                else
                    slot_link[t] = slot_link[h];
                slot_link[h] = LINK_TAKEN;
                r.slot_index = cfl_pkg::SLOT_W'(h);
            end
        end
        else
        begin
            if (idx >= n)
                r.status = cfl_pkg::ST_OUT_RANGE;
            else if (slot_link[idx] != LINK_TAKEN)
                r.status = cfl_pkg::ST_ALREADY;
            else if (pool_drained)
            begin
                slot_link[idx] = 7'(idx);
                tail_slot_m = idx;
                pool_drained = 1'b0;
            end
            else
            begin
                t = tail_slot_m % n;
                slot_link[idx] = slot_link[t];
                slot_link[t] = 7'(idx);
                if (b.conn_alive == 1'b0)
                    tail_slot_m = idx;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        err_count++;
        $display("mismatch at %0t ns: %s got %0d expected %0d", $time, what, got, want);
    endtask

    always @(posedge clk)
    begin : monitor
        beat_note_t          note;
        cfl_pkg::out_beat_t  pred;
        cfl_pkg::out_beat_t  want;
        bit                  moved;
        moved = 1'b0;
        if (!rst_n)
        begin
            pool_size_m = 7'd64;
            rebuild_pool();
        end
        else
        begin
            if (cfg_wr_en)
            begin
                pool_size_m = cfg_wr_data;
                rebuild_pool();
            end
            if (in_valid && !in_stall)
            begin
                moved = 1'b1;
                pred = predict_grant(in_data);
                note.typed = 1'b0;
                if (beat_notes.size() != 0)
                    note = beat_notes.pop_front();
                expected_grants.push_back(note.typed ? note.result : pred);
                beats_in++;
            end
            if (out_valid && !out_stall)
            begin
                moved = 1'b1;
                beats_out++;
                if (expected_grants.size() == 0)
                    report_mismatch("result beat with nothing pending, slot",
                                    int'(out_data.slot_index), 0);
                else
                begin
                    want = expected_grants.pop_front();
                    if (out_data.status !== want.status)
                        report_mismatch("status", int'(out_data.status), int'(want.status));
                    if (out_data.slot_index !== want.slot_index)
                        report_mismatch("slot_index", int'(out_data.slot_index),
                                        int'(want.slot_index));
                end
            end
            if (moved)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // result side back-pressure
    initial
    begin : result_sink
        int gap;
        int seen;
        out_stall = 1'b0;
        out_burst = 1'b0;
        forever
        begin
            if ($urandom_range(0, 49) == 0)
                out_burst = !out_burst;
            gap = out_burst ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(negedge clk);
            end
            out_stall <= 1'b0;
            seen = beats_out;
            do @(negedge clk); while (beats_out == seen);
        end
    end

    task automatic send_beat(input cfl_pkg::in_beat_t b, input bit typed,
                             input cfl_pkg::out_beat_t r);
        int gap;
        int target;
        beat_note_t note;
        gap = in_burst ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        note.typed = typed;
        note.result = r;
        beat_notes.push_back(note);
        target = beats_in + 1;
        in_valid <= 1'b1;
        in_data <= b;
        do @(negedge clk); while (beats_in < target);
    endtask

    task automatic drain_pool();
        in_valid <= 1'b0;
        do @(negedge clk); while (expected_grants.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_size(input logic [cfl_pkg::SIZE_W-1:0] v);
        drain_pool();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic stim_row_t op_row(input logic op, input int idx, input logic alive,
                                         input bit typed, input logic [1:0] st,
                                         input int slot);
        stim_row_t row;
        row.is_cfg = 1'b0;
        row.size_val = '0;
        row.beat.opcode = op;
        row.beat.release_index = cfl_pkg::SLOT_W'(idx);
        row.beat.conn_alive = alive;
        row.typed = typed;
        row.result.status = st;
        row.result.slot_index = cfl_pkg::SLOT_W'(slot);
        return row;
    endfunction

    function automatic stim_row_t size_row(input int v);
        stim_row_t row;
        row = op_row(cfl_pkg::OP_ACQUIRE, 0, 1'b0, 1'b0, cfl_pkg::ST_OK, 0);
        row.is_cfg = 1'b1;
        row.size_val = cfl_pkg::SIZE_W'(v);
        return row;
    endfunction

    function automatic cfl_pkg::in_beat_t random_beat(input int acq_pct);
        cfl_pkg::in_beat_t b;
        int n;
        int busy [$];
        n = live_slots();
        b.opcode = ($urandom_range(0, 99) < acq_pct) ? cfl_pkg::OP_ACQUIRE
                                                     : cfl_pkg::OP_RELEASE;
        b.release_index = cfl_pkg::SLOT_W'($urandom_range(0, 63));
        b.conn_alive = 1'($urandom_range(0, 1));
        // mostly hand back a slot that is really out
        if (b.opcode == cfl_pkg::OP_RELEASE && $urandom_range(0, 3) != 0)
        begin
            for (int k = 0; k < n; k++)
                if (slot_link[k] == LINK_TAKEN)
                    busy.push_back(k);
            if (busy.size() != 0)
                b.release_index =
                    cfl_pkg::SLOT_W'(busy[$urandom_range(0, busy.size() - 1)]);
        end
        return b;
    endfunction

    initial
    begin : stimulus
        stim_row_t rows [$];
        cfl_pkg::out_beat_t none;
        in_valid = 1'b0;
        in_data = '0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        rst_n = 1'b0;
        beats_in = 0;
        beats_out = 0;
        err_count = 0;
        quiet_cycles = 0;
        in_burst = 1'b0;
        none = '0;
        pool_size_m = 7'd64;
        rebuild_pool();
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // size 64 after reset
        rows.push_back(op_row(cfl_pkg::OP_ACQUIRE, 63, 1'b1, 1'b1, cfl_pkg::ST_OK, 0));
        rows.push_back(op_row(cfl_pkg::OP_ACQUIRE, 0, 1'b0, 1'b1, cfl_pkg::ST_OK, 1));
        rows.push_back(op_row(cfl_pkg::OP_RELEASE, 63, 1'b1, 1'b1, cfl_pkg::ST_ALREADY, 0));
        rows.push_back(op_row(cfl_pkg::OP_RELEASE, 0, 1'b1, 1'b1, cfl_pkg::ST_OK, 0));
        rows.push_back(op_row(cfl_pkg::OP_ACQUIRE, 0, 1'b0, 1'b0, cfl_pkg::ST_OK, 0));
        rows.push_back(op_row(cfl_pkg::OP_RELEASE, 1, 1'b0, 1'b1, cfl_pkg::ST_OK, 0));
        rows.push_back(op_row(cfl_pkg::OP_ACQUIRE, 42, 1'b1, 1'b0, cfl_pkg::ST_OK, 0));
        // single slot, empty list, out of range
        rows.push_back(size_row(1));
        rows.push_back(op_row(cfl_pkg::OP_ACQUIRE, 0, 1'b0, 1'b1, cfl_pkg::ST_OK, 0));
        rows.push_back(op_row(cfl_pkg::OP_ACQUIRE, 0, 1'b0, 1'b1, cfl_pkg::ST_EMPTY, 0));
        rows.push_back(op_row(cfl_pkg::OP_RELEASE, 1, 1'b1, 1'b1, cfl_pkg::ST_OUT_RANGE, 0));
        rows.push_back(op_row(cfl_pkg::OP_RELEASE, 0, 1'b1, 1'b1, cfl_pkg::ST_OK, 0));
        rows.push_back(op_row(cfl_pkg::OP_RELEASE, 0, 1'b0, 1'b1, cfl_pkg::ST_ALREADY, 0));
        rows.push_back(op_row(cfl_pkg::OP_ACQUIRE, 0, 1'b0, 1'b0, cfl_pkg::ST_OK, 0));
        // size zero clamps to one
        rows.push_back(size_row(0));
        rows.push_back(op_row(cfl_pkg::OP_ACQUIRE, 0, 1'b0, 1'b1, cfl_pkg::ST_OK, 0));
        rows.push_back(op_row(cfl_pkg::OP_RELEASE, 63, 1'b1, 1'b1, cfl_pkg::ST_OUT_RANGE, 0));
        // oversize clamps to 64
        rows.push_back(size_row(127));
        rows.push_back(op_row(cfl_pkg::OP_RELEASE, 63, 1'b0, 1'b1, cfl_pkg::ST_ALREADY, 0));
        rows.push_back(op_row(cfl_pkg::OP_ACQUIRE, 0, 1'b0, 1'b1, cfl_pkg::ST_OK, 0));
        rows.push_back(op_row(cfl_pkg::OP_RELEASE, 0, 1'b0, 1'b0, cfl_pkg::ST_OK, 0));
        // two slots: drain, refill into empty list, dead release to tail
        rows.push_back(size_row(2));
        rows.push_back(op_row(cfl_pkg::OP_ACQUIRE, 0, 1'b0, 1'b1, cfl_pkg::ST_OK, 0));
        rows.push_back(op_row(cfl_pkg::OP_ACQUIRE, 0, 1'b0, 1'b1, cfl_pkg::ST_OK, 1));
        rows.push_back(op_row(cfl_pkg::OP_RELEASE, 1, 1'b1, 1'b0, cfl_pkg::ST_OK, 0));
        rows.push_back(op_row(cfl_pkg::OP_RELEASE, 0, 1'b0, 1'b0, cfl_pkg::ST_OK, 0));
        rows.push_back(op_row(cfl_pkg::OP_ACQUIRE, 0, 1'b0, 1'b0, cfl_pkg::ST_OK, 0));
        rows.push_back(op_row(cfl_pkg::OP_ACQUIRE, 0, 1'b0, 1'b0, cfl_pkg::ST_OK, 0));

        foreach (rows[i])
        begin
            if (rows[i].is_cfg)
                write_size(rows[i].size_val);
            else
                send_beat(rows[i].beat, rows[i].typed, rows[i].result);
        end

        // random phases: acquire-heavy half drains the pool, release-heavy half refills it
        foreach (PHASE_SIZES[p])
        begin
            write_size(cfl_pkg::SIZE_W'(PHASE_SIZES[p]));
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (i % 40 == 0)
                    in_burst = ($urandom_range(0, 3) == 0);
                send_beat(random_beat(ACQ_PCT[(2 * i) / PHASE_ITEMS]), 1'b0, none);
            end
        end

        drain_pool();
        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/cfl_pkg.sv
rtl/cfl_list.sv
rtl/circular_free_list_pool.sv
bench/tb.sv
